FILE: design/twma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_pkg
// Shared types, constants and the microcode program of the time weighted
// moving average block.
// ----------------------------------------------------------------------------
package twma_pkg;

  localparam int MAX_GAP_SECONDS_DEF = 10;
  localparam int FRACTION_BITS_DEF   = 16;

  localparam int TS_W  = 48;
  localparam int SMP_W = 32;
  localparam int AVG_W = 32;
  localparam int WIN_W = 32;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int CFG_IDX_W = CFG_AW - 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);

  typedef struct packed {
    logic                    func;
    logic [TS_W-1:0]         timestamp;
    logic signed [SMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             accepted;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_GAP,
    OP_DIV_W,
    OP_W_SAT,
    OP_DIV_X,
    OP_X_SAT,
    OP_MUL_A,
    OP_MUL_B,
    OP_BLEND,
    OP_COMMIT,
    OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_ITEM,
    C_NEG,
    C_DIV_BUSY,
    C_PLAIN,
    C_GAP_ZERO,
    C_OUT_BUSY
  } jcond_t;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_GAP    = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_WDIV   = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_WWAIT  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_WSAT   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_XDIV   = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_XWAIT  = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_XSAT   = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_MULA   = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_MULB   = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_BLEND  = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_COMMIT = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_OUT    = STEP_W'(12);

  typedef struct packed {
    dp_op_t            op;
    jcond_t            cond;
    logic [STEP_W-1:0] target;
    logic              fin;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic neg;
    logic plain;
    logic gap_zero;
    logic div_busy;
    logic out_busy;
  } seq_stat_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '{op: OP_NOP, cond: C_NONE, target: STEP_IDLE, fin: 1'b0};
    unique case (step)
      STEP_IDLE:   u = '{op: OP_CAPTURE, cond: C_NO_ITEM,  target: STEP_IDLE,   fin: 1'b0};
      STEP_GAP:    u = '{op: OP_GAP,     cond: C_NEG,      target: STEP_OUT,    fin: 1'b0};
      STEP_WDIV:   u = '{op: OP_DIV_W,   cond: C_NONE,     target: STEP_IDLE,   fin: 1'b0};
      STEP_WWAIT:  u = '{op: OP_NOP,     cond: C_DIV_BUSY, target: STEP_WWAIT,  fin: 1'b0};
      STEP_WSAT:   u = '{op: OP_W_SAT,   cond: C_PLAIN,    target: STEP_MULA,   fin: 1'b0};
      STEP_XDIV:   u = '{op: OP_DIV_X,   cond: C_GAP_ZERO, target: STEP_COMMIT, fin: 1'b0};
      STEP_XWAIT:  u = '{op: OP_NOP,     cond: C_DIV_BUSY, target: STEP_XWAIT,  fin: 1'b0};
      STEP_XSAT:   u = '{op: OP_X_SAT,   cond: C_NONE,     target: STEP_IDLE,   fin: 1'b0};
      STEP_MULA:   u = '{op: OP_MUL_A,   cond: C_NONE,     target: STEP_IDLE,   fin: 1'b0};
      STEP_MULB:   u = '{op: OP_MUL_B,   cond: C_NONE,     target: STEP_IDLE,   fin: 1'b0};
      STEP_BLEND:  u = '{op: OP_BLEND,   cond: C_NONE,     target: STEP_IDLE,   fin: 1'b0};
      STEP_COMMIT: u = '{op: OP_COMMIT,  cond: C_NONE,     target: STEP_IDLE,   fin: 1'b0};
      STEP_OUT:    u = '{op: OP_OUT,     cond: C_OUT_BUSY, target: STEP_OUT,    fin: 1'b1};
      default:     u = '{op: OP_NOP,     cond: C_NONE,     target: STEP_IDLE,   fin: 1'b1};
    endcase
    return u;
  endfunction

endpackage

FILE: design/twma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twma_div #(
  parameter int DIV_N = 47,
  parameter int DIV_D = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic             busy,
  output logic [DIV_N-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_N + 1);

  logic [DIV_D-1:0] rem_r, rem_nxt;
  logic [DIV_N-1:0] quo_r, quo_nxt;
  logic [DIV_D-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DIV_D:0]   trial;
  logic [DIV_D:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_N-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
      quo_nxt = {quo_r[DIV_N-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: design/twma_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_dp
// Datapath: item registers, clamped gap, weight and rate division, blend
// multiplies and the running state.
// ----------------------------------------------------------------------------
module twma_dp #(
  parameter int MAX_GAP_SECONDS = twma_pkg::MAX_GAP_SECONDS_DEF,
  parameter int FRACTION_BITS   = twma_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  twma_pkg::ucode_t            ctrl,
  input  logic                        in_accept,
  input  twma_pkg::in_item_t          in_item,
  input  logic [twma_pkg::WIN_W-1:0]  window,
  output logic                        neg,
  output logic                        plain,
  output logic                        gap_zero,
  output logic                        div_busy,
  output twma_pkg::out_item_t         result
);

  localparam logic [63:0] GAP_MAX = 64'(MAX_GAP_SECONDS) << FRACTION_BITS;
  localparam int GAP_W  = $clog2(GAP_MAX + 64'd1);
  localparam int W_W    = FRACTION_BITS + 1;
  localparam int DIV_N  = (GAP_W > 31) ? GAP_W + FRACTION_BITS : 31 + FRACTION_BITS;
  localparam int DIV_D  = (GAP_W > twma_pkg::WIN_W) ? GAP_W : twma_pkg::WIN_W;
  localparam int PROD_W = twma_pkg::AVG_W + W_W;
  localparam logic [W_W-1:0]   ONE_W   = W_W'(1) << FRACTION_BITS;
  localparam logic [DIV_N-1:0] ONE_Q   = DIV_N'(1) << FRACTION_BITS;
  localparam logic [DIV_N-1:0] MAX32_Q = DIV_N'(64'hFFFF_FFFF);

  logic                          func_r, func_nxt;
  logic [twma_pkg::TS_W-1:0]     ts_r, ts_nxt;
  logic [twma_pkg::SMP_W-1:0]    smp_r, smp_nxt;
  logic [GAP_W-1:0]              gap_r, gap_nxt;
  logic [W_W-1:0]                w_r, w_nxt;
  logic [twma_pkg::AVG_W-1:0]    x_r, x_nxt;
  logic [PROD_W-1:0]             pa_r, pa_nxt;
  logic [PROD_W-1:0]             pb_r, pb_nxt;
  logic [twma_pkg::AVG_W-1:0]    avg_r, avg_nxt;
  logic [twma_pkg::TS_W-1:0]     last_r, last_nxt;

  logic [twma_pkg::TS_W-1:0]     diff;
  logic [GAP_W-1:0]              gap_c;
  logic                          div_start;
  logic [DIV_N-1:0]              div_dividend;
  logic [DIV_D-1:0]              div_divisor;
  logic [DIV_N-1:0]              quo;
  logic [PROD_W:0]               sum;

  twma_div #(
    .DIV_N (DIV_N),
    .DIV_D (DIV_D)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    diff = ts_r - last_r;
    if (ts_r < last_r) begin
      gap_c = '0;
    end else if (64'(diff) > GAP_MAX) begin
      gap_c = GAP_W'(GAP_MAX);
    end else begin
      gap_c = GAP_W'(diff);
    end
  end

  always_comb begin
    div_start    = (ctrl.op == twma_pkg::OP_DIV_W) || (ctrl.op == twma_pkg::OP_DIV_X);
    div_dividend = DIV_N'({gap_r, {FRACTION_BITS{1'b0}}});
    div_divisor  = DIV_D'(window);
    if (ctrl.op == twma_pkg::OP_DIV_X) begin
      div_dividend = DIV_N'({smp_r[twma_pkg::SMP_W-2:0], {FRACTION_BITS{1'b0}}});
      div_divisor  = DIV_D'(gap_r);
    end
  end

  always_comb begin
    sum      = (PROD_W + 1)'(pa_r) + (PROD_W + 1)'(pb_r);
    func_nxt = func_r;
    ts_nxt   = ts_r;
    smp_nxt  = smp_r;
    gap_nxt  = gap_r;
    w_nxt    = w_r;
    x_nxt    = x_r;
    pa_nxt   = pa_r;
    pb_nxt   = pb_r;
    avg_nxt  = avg_r;
    last_nxt = last_r;
    unique case (ctrl.op)
      twma_pkg::OP_CAPTURE: begin
        if (in_accept) begin
          func_nxt = in_item.func;
          ts_nxt   = in_item.timestamp;
          smp_nxt  = in_item.sample;
        end
      end
      twma_pkg::OP_GAP: begin
        gap_nxt = gap_c;
      end
      twma_pkg::OP_W_SAT: begin
        if (window == '0 || quo > ONE_Q) begin
          w_nxt = ONE_W;
        end else begin
          w_nxt = quo[W_W-1:0];
        end
        x_nxt = {1'b0, smp_r[twma_pkg::SMP_W-2:0]};
      end
      twma_pkg::OP_X_SAT: begin
        x_nxt = (quo > MAX32_Q) ? '1 : quo[twma_pkg::AVG_W-1:0];
      end
      twma_pkg::OP_MUL_A: begin
        pa_nxt = PROD_W'(avg_r) * PROD_W'(ONE_W - w_r);
      end
      twma_pkg::OP_MUL_B: begin
        pb_nxt = PROD_W'(x_r) * PROD_W'(w_r);
      end
      twma_pkg::OP_BLEND: begin
        avg_nxt = sum[FRACTION_BITS +: twma_pkg::AVG_W];
      end
      twma_pkg::OP_COMMIT: begin
        last_nxt = ts_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r  <= '0;
      last_r <= '0;
    end else begin
      avg_r  <= avg_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    ts_r   <= ts_nxt;
    smp_r  <= smp_nxt;
    gap_r  <= gap_nxt;
    w_r    <= w_nxt;
    x_r    <= x_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
  end

  assign neg      = smp_r[twma_pkg::SMP_W-1];
  assign plain    = !func_r;
  assign gap_zero = (gap_r == '0);
  assign result   = '{average: avg_r, accepted: !smp_r[twma_pkg::SMP_W-1]};

endmodule

FILE: design/twma_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_seq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module twma_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  twma_pkg::seq_stat_t  stat,
  output twma_pkg::ucode_t     ctrl
);

  logic [twma_pkg::STEP_W-1:0] step_r, step_nxt;
  twma_pkg::ucode_t            uword;
  logic                        jump;

  always_comb begin
    uword = twma_pkg::ucode_rom(step_r);
    unique case (uword.cond)
      twma_pkg::C_NO_ITEM:  jump = !stat.in_valid;
      twma_pkg::C_NEG:      jump = stat.neg;
      twma_pkg::C_DIV_BUSY: jump = stat.div_busy;
      twma_pkg::C_PLAIN:    jump = stat.plain;
      twma_pkg::C_GAP_ZERO: jump = stat.gap_zero;
      twma_pkg::C_OUT_BUSY: jump = stat.out_busy;
      default:              jump = 1'b0;
    endcase
    priority if (jump) begin
      step_nxt = uword.target;
    end else if (uword.fin) begin
      step_nxt = twma_pkg::STEP_IDLE;
    end else begin
      step_nxt = step_r + twma_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= twma_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl = uword;

endmodule

FILE: design/time_weighted_moving_average.sv
`timescale 1ns / 1ps
// Sequence: a plain item runs one division, a rate item two (the second is abandoned
//   at zero gap), a negative sample none; divider width DIV_N = FRACTION_BITS + 31.
// Flow: one item at a time; the next item is taken the cycle after the result enters
//   the output register. Non-negative items wait on the single bit-per-cycle divider.
// Reset: synchronous active-low rst_n clears average and last time to zero and
//   sets window_duration to 1.0.
// ----------------------------------------------------------------------------
// time_weighted_moving_average
// Time weighted exponential moving average with an APB window register.
// ----------------------------------------------------------------------------
module time_weighted_moving_average #(
  parameter int MAX_GAP_SECONDS = twma_pkg::MAX_GAP_SECONDS_DEF,
  parameter int FRACTION_BITS   = twma_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  twma_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output twma_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [twma_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [twma_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [twma_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam logic [twma_pkg::WIN_W-1:0] WIN_RESET = twma_pkg::WIN_W'(1) << FRACTION_BITS;

  logic [twma_pkg::WIN_W-1:0] wd_r, wd_nxt;
  logic                       out_valid_r, out_valid_nxt;
  twma_pkg::out_item_t        out_data_r, out_data_nxt;

  twma_pkg::ucode_t           ctrl;
  twma_pkg::seq_stat_t        stat;
  twma_pkg::out_item_t        result;
  logic                       dp_neg;
  logic                       dp_plain;
  logic                       dp_gap_zero;
  logic                       dp_div_busy;
  logic                       cfg_wr;
  logic                       sel_window;
  logic                       out_busy;
  logic                       out_load;

  assign cfg_pready = 1'b1;
  assign sel_window = (cfg_paddr[twma_pkg::CFG_AW-1:2] == twma_pkg::REG_WINDOW);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = sel_window ? twma_pkg::CFG_DW'(wd_r) : '0;

  assign in_ready = (ctrl.op == twma_pkg::OP_CAPTURE);
  assign out_busy = out_valid_r && !out_ready;
  assign out_load = (ctrl.op == twma_pkg::OP_OUT) && !out_busy;

  always_comb begin
    stat = '{in_valid: in_valid, neg: dp_neg, plain: dp_plain, gap_zero: dp_gap_zero,
             div_busy: dp_div_busy, out_busy: out_busy};
  end

  twma_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  twma_dp #(
    .MAX_GAP_SECONDS (MAX_GAP_SECONDS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_accept (in_valid && in_ready),
    .in_item   (in_data),
    .window    (wd_r),
    .neg       (dp_neg),
    .plain     (dp_plain),
    .gap_zero  (dp_gap_zero),
    .div_busy  (dp_div_busy),
    .result    (result)
  );

  always_comb begin
    wd_nxt        = wd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cfg_wr && sel_window) begin
      wd_nxt = twma_pkg::WIN_W'(cfg_pwdata);
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r        <= WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      wd_r        <= wd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_capture_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (ctrl.op == twma_pkg::OP_GAP))
    else $error("accepted item not followed by gap step");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_wr && sel_window) |=> $stable(wd_r))
    else $error("window register changed without a write");

  a_negative_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && dp_neg) |=> !out_data_r.accepted)
    else $error("negative sample reported as accepted");
`endif

endmodule
